// ----- hdl/modbus_register_function_engine_top_defines.svh -----
// assertion helpers used by the engine top
`ifndef MODBUS_REGISTER_FUNCTION_ENGINE_TOP_DEFINES_SVH
`define MODBUS_REGISTER_FUNCTION_ENGINE_TOP_DEFINES_SVH

// property checked at every edge outside reset
`define MRFE_AST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define MRFE_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/mrfe_pkg.sv -----
package mrfe_pkg;

  localparam int IDXW = 13;

  localparam logic [7:0] FC_RD_HOLD  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT = 8'd4;
  localparam logic [7:0] FC_WR_ONE   = 8'd6;
  localparam logic [7:0] FC_WR_MULTI = 8'd16;
  localparam logic [7:0] FC_RD_WR    = 8'd23;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;
  localparam logic [7:0] EXC_FLAG    = 8'h80;

  localparam logic [1:0] EX_NONE  = 2'd0;
  localparam logic [1:0] EX_FUNC  = 2'd1;
  localparam logic [1:0] EX_ADDR  = 2'd2;
  localparam logic [1:0] EX_VALUE = 2'd3;

  localparam logic [1:0] REG_HOLD_BASE  = 2'd0;
  localparam logic [1:0] REG_HOLD_COUNT = 2'd1;
  localparam logic [1:0] REG_IN_BASE    = 2'd2;
  localparam logic [1:0] REG_IN_COUNT   = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_WR_A, ST_WR_B, ST_WR_C,
    ST_RD_HDR, ST_RD_A, ST_RD_D, ST_ECHO0, ST_ECHO1, ST_ECHO2, ST_EXC
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       last;
    logic [1:0] exc;
  } push_t;

  function automatic logic in_window(input logic [15:0] addr, input logic [16:0] cnt,
                                     input logic [15:0] base, input logic [IDXW-1:0] used);
    logic [17:0] hi_req;
    logic [17:0] hi_win;
    hi_req = 18'(addr) + 18'(cnt);
    hi_win = 18'(base) + 18'(used);
    return (addr >= base) && (hi_req <= hi_win);
  endfunction

endpackage

// ----- hdl/mrfe_ram.sv -----
module mrfe_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/mrfe_pack.sv -----
module mrfe_pack (
  input  logic               clk,
  input  logic               rst,
  input  mrfe_pkg::push_t    push,
  output logic               push_ready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,
  output logic               m_tlast,
  output logic [1:0]         m_tuser
);

  logic        half;
  logic [15:0] acc;
  logic        completes;
  logic [7:0]  b1_eff;

  assign completes  = half || push.last;
  assign push_ready = !completes || !m_tvalid || m_tready;
  assign b1_eff     = push.two ? push.b1 : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      half     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (push.valid && push_ready) begin
        if (completes) begin
          m_tvalid <= 1'b1;
          half     <= 1'b0;
          m_tlast  <= push.last;
          m_tuser  <= push.exc;
          if (half) begin
            m_tdata <= {5'd0, push.two ? 3'd4 : 3'd3, acc, push.b0, b1_eff};
          end else begin
            m_tdata <= {5'd0, push.two ? 3'd2 : 3'd1, push.b0, b1_eff, 16'h0000};
          end
        end else begin
          acc  <= {push.b0, push.b1};
          half <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/modbus_register_function_engine_top.sv -----
// request bytes are taken one per cycle while idle; the last one leads to the check state
// read of c registers: check, header push, then an address and a data step per register
// write of w registers: check, two buffer reads and a store per register, three echo pushes
// function 23: check, writes as above, then header and reads, or exception on read miss
// exception: check, then a single push; every push waits while the output is stalled
// after reset both stores are zeroed in the clear state, and no request is taken there
module modbus_register_function_engine_top #(
  parameter int HOLD_DEPTH        = 64,
  parameter int INPUT_DEPTH       = 64,
  parameter int PDU_BUFFER        = 256,
  parameter int MAX_READ_REGS     = 125,
  parameter int MAX_WRITE_REGS    = 123,
  parameter int MAX_RW_WRITE_REGS = 121
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pdu_byte[7:0], upd_index[13:8], upd_value[29:14]
  input  logic        s_tlast,   // pdu_last
  input  logic [0:0]  s_tuser,   // req_type
  // response side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // resp_bytes[31:0], resp_count[34:32]
  output logic        m_tlast,   // resp_last
  output logic [1:0]  m_tuser,   // exception
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

`include "modbus_register_function_engine_top_defines.svh"

  localparam int HAW   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int IAW   = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int BAW   = $clog2(PDU_BUFFER);
  localparam int LW    = $clog2(PDU_BUFFER + 2);
  localparam int CLR_N = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;
  localparam int CLRW  = $clog2(CLR_N + 1);
  localparam int IDXW  = mrfe_pkg::IDXW;

  // configuration registers
  logic [15:0] holding_base;
  logic [6:0]  holding_count;
  logic [15:0] input_base;
  logic [6:0]  input_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_base  <= 16'd0;
      holding_count <= 7'd64;
      input_base    <= 16'd0;
      input_count   <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        mrfe_pkg::REG_HOLD_BASE:  holding_base  <= cfg_data;
        mrfe_pkg::REG_HOLD_COUNT: holding_count <= cfg_data[6:0];
        mrfe_pkg::REG_IN_BASE:    input_base    <= cfg_data;
        mrfe_pkg::REG_IN_COUNT:   input_count   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic        req_type;
  logic [7:0]  pdu_byte;
  logic [5:0]  upd_index;
  logic [15:0] upd_value;
  assign req_type  = s_tuser[0];
  assign pdu_byte  = s_tdata[7:0];
  assign upd_index = s_tdata[13:8];
  assign upd_value = s_tdata[29:14];

  mrfe_pkg::state_t state, state_next;

  logic [CLRW-1:0] clr;
  logic [LW-1:0]   req_len;
  logic [7:0]      hdr [10];
  logic [8:0]      src;        // buffer position of next write data byte
  logic [6:0]      wi, wn;     // write loop index and length
  logic [IDXW-1:0] widx;
  logic [6:0]      ri, rn;     // read loop index and length
  logic [IDXW-1:0] ridx;
  logic            rd_input;
  logic            rd_bad;     // read window miss found ahead on function 23
  logic [1:0]      exc;
  logic [7:0]      hi_byte;

  logic accept;
  assign s_tready = (state == mrfe_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // decoded request fields
  logic [7:0]  fc;
  logic [15:0] addr_w, cnt_w, waddr_w, wcnt_w;
  logic [7:0]  bc5, bc9;
  assign fc      = hdr[0];
  assign addr_w  = {hdr[1], hdr[2]};
  assign cnt_w   = {hdr[3], hdr[4]};
  assign waddr_w = {hdr[5], hdr[6]};
  assign wcnt_w  = {hdr[7], hdr[8]};
  assign bc5     = hdr[5];
  assign bc9     = hdr[9];

  logic [IDXW-1:0] used_hold, used_input;
  assign used_hold  = (IDXW'(holding_count) < IDXW'(HOLD_DEPTH)) ?
                      IDXW'(holding_count) : IDXW'(HOLD_DEPTH);
  assign used_input = (IDXW'(input_count) < IDXW'(INPUT_DEPTH)) ?
                      IDXW'(input_count) : IDXW'(INPUT_DEPTH);

  // length of the request that just ended, captured with its last byte
  logic [LW-1:0] len_hold;

  // request check, used in the cycle after the last byte
  logic [1:0]      chk_code;
  logic            chk_write, chk_read, chk_rbad;
  logic [17:0]     len_x;
  logic            cnt_rd_ok, wr_cnt_ok, rw_cnt_ok;
  logic [15:0]     rd_base;
  logic [IDXW-1:0] rd_used;

  always_comb begin
    chk_code  = mrfe_pkg::EX_NONE;
    chk_write = 1'b0;
    chk_read  = 1'b0;
    chk_rbad  = 1'b0;
    len_x     = 18'(len_hold);
    cnt_rd_ok = (cnt_w >= 16'd1) && (cnt_w <= 16'(MAX_READ_REGS));
    wr_cnt_ok = (cnt_w >= 16'd1) && (cnt_w <= 16'(MAX_WRITE_REGS)) &&
                ({9'd0, bc5} == {cnt_w, 1'b0});
    rw_cnt_ok = cnt_rd_ok && (wcnt_w >= 16'd1) && (wcnt_w <= 16'(MAX_RW_WRITE_REGS)) &&
                ({9'd0, bc9} == {wcnt_w, 1'b0});
    rd_base   = (fc == mrfe_pkg::FC_RD_INPUT) ? input_base : holding_base;
    rd_used   = (fc == mrfe_pkg::FC_RD_INPUT) ? used_input : used_hold;
    case (fc)
      mrfe_pkg::FC_RD_HOLD, mrfe_pkg::FC_RD_INPUT: begin
        if (len_x != 18'd5 || !cnt_rd_ok) begin
          chk_code = mrfe_pkg::EX_VALUE;
        end else if (!mrfe_pkg::in_window(addr_w, 17'(cnt_w), rd_base, rd_used)) begin
          chk_code = mrfe_pkg::EX_ADDR;
        end else begin
          chk_read = 1'b1;
        end
      end
      mrfe_pkg::FC_WR_ONE: begin
        if (len_x != 18'd5) begin
          chk_code = mrfe_pkg::EX_VALUE;
        end else if (!mrfe_pkg::in_window(addr_w, 17'd1, holding_base, used_hold)) begin
          chk_code = mrfe_pkg::EX_ADDR;
        end else begin
          chk_write = 1'b1;
        end
      end
      mrfe_pkg::FC_WR_MULTI: begin
        if (len_x < 18'd6 || !wr_cnt_ok || len_x < 18'd6 + {1'b0, cnt_w, 1'b0}) begin
          chk_code = mrfe_pkg::EX_VALUE;
        end else if (!mrfe_pkg::in_window(addr_w, 17'(cnt_w), holding_base, used_hold)) begin
          chk_code = mrfe_pkg::EX_ADDR;
        end else begin
          chk_write = 1'b1;
        end
      end
      mrfe_pkg::FC_RD_WR: begin
        if (len_x < 18'd10 || !rw_cnt_ok || len_x < 18'd10 + {1'b0, wcnt_w, 1'b0}) begin
          chk_code = mrfe_pkg::EX_VALUE;
        end else if (!mrfe_pkg::in_window(waddr_w, 17'(wcnt_w), holding_base, used_hold)) begin
          chk_code = mrfe_pkg::EX_ADDR;
        end else begin
          chk_write = 1'b1;
          chk_rbad  = !mrfe_pkg::in_window(addr_w, 17'(cnt_w), holding_base, used_hold);
        end
      end
      default: chk_code = mrfe_pkg::EX_FUNC;
    endcase
    // buffer overflow beats everything but an unknown function
    if (chk_code != mrfe_pkg::EX_FUNC && len_x > 18'(PDU_BUFFER)) begin
      chk_code  = mrfe_pkg::EX_VALUE;
      chk_write = 1'b0;
      chk_read  = 1'b0;
    end
  end

  // memory ports
  logic            buf_we, buf_re;
  logic [BAW-1:0]  buf_waddr, buf_raddr;
  logic [7:0]      buf_rdata;
  logic            hold_we, hold_re;
  logic [HAW-1:0]  hold_waddr;
  logic [15:0]     hold_wdata, hold_rdata;
  logic            in_we, in_re;
  logic [IAW-1:0]  in_waddr;
  logic [15:0]     in_wdata, in_rdata;
  logic [IDXW-1:0] upd_ext;
  logic [15:0]     rd_word;

  mrfe_pkg::push_t push;
  logic            push_ready;
  logic            rd_done, wr_done;

  assign upd_ext = IDXW'(upd_index);
  assign rd_word = rd_input ? in_rdata : hold_rdata;
  assign rd_done = (ri == rn - 7'd1);
  assign wr_done = (wi == wn - 7'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrfe_pkg::ST_CLEAR:
        if (clr == CLRW'(CLR_N - 1)) state_next = mrfe_pkg::ST_IDLE;
      mrfe_pkg::ST_IDLE:
        if (accept && !req_type && s_tlast) state_next = mrfe_pkg::ST_CHECK;
      mrfe_pkg::ST_CHECK: begin
        if (chk_code != mrfe_pkg::EX_NONE) state_next = mrfe_pkg::ST_EXC;
        else if (chk_write)                state_next = mrfe_pkg::ST_WR_A;
        else if (chk_read)                 state_next = mrfe_pkg::ST_RD_HDR;
        else                               state_next = mrfe_pkg::ST_IDLE;
      end
      mrfe_pkg::ST_WR_A: state_next = mrfe_pkg::ST_WR_B;
      mrfe_pkg::ST_WR_B: state_next = mrfe_pkg::ST_WR_C;
      mrfe_pkg::ST_WR_C: begin
        if (!wr_done)                     state_next = mrfe_pkg::ST_WR_A;
        else if (fc != mrfe_pkg::FC_RD_WR) state_next = mrfe_pkg::ST_ECHO0;
        else if (rd_bad)                  state_next = mrfe_pkg::ST_EXC;
        else                              state_next = mrfe_pkg::ST_RD_HDR;
      end
      mrfe_pkg::ST_RD_HDR: if (push_ready) state_next = mrfe_pkg::ST_RD_A;
      mrfe_pkg::ST_RD_A:   state_next = mrfe_pkg::ST_RD_D;
      mrfe_pkg::ST_RD_D:
        if (push_ready) state_next = rd_done ? mrfe_pkg::ST_IDLE : mrfe_pkg::ST_RD_A;
      mrfe_pkg::ST_ECHO0: if (push_ready) state_next = mrfe_pkg::ST_ECHO1;
      mrfe_pkg::ST_ECHO1: if (push_ready) state_next = mrfe_pkg::ST_ECHO2;
      mrfe_pkg::ST_ECHO2: if (push_ready) state_next = mrfe_pkg::ST_IDLE;
      mrfe_pkg::ST_EXC:   if (push_ready) state_next = mrfe_pkg::ST_IDLE;
      default: state_next = mrfe_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory controls and response bytes
  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = req_len[BAW-1:0];
    buf_re     = 1'b0;
    buf_raddr  = src[BAW-1:0];
    hold_we    = 1'b0;
    hold_waddr = clr[HAW-1:0];
    hold_wdata = 16'h0000;
    hold_re    = 1'b0;
    in_we      = 1'b0;
    in_waddr   = clr[IAW-1:0];
    in_wdata   = 16'h0000;
    in_re      = 1'b0;
    push       = '0;
    case (state)
      mrfe_pkg::ST_CLEAR: begin
        hold_we = (clr < CLRW'(HOLD_DEPTH));
        in_we   = (clr < CLRW'(INPUT_DEPTH));
      end
      mrfe_pkg::ST_IDLE: begin
        buf_we   = accept && !req_type && (req_len < LW'(PDU_BUFFER));
        in_we    = accept && req_type && (upd_ext < IDXW'(INPUT_DEPTH));
        in_waddr = upd_ext[IAW-1:0];
        in_wdata = upd_value;
      end
      mrfe_pkg::ST_WR_A: buf_re = 1'b1;
      mrfe_pkg::ST_WR_B: begin
        buf_re    = 1'b1;
        buf_raddr = BAW'(src + 9'd1);
      end
      mrfe_pkg::ST_WR_C: begin
        hold_we    = 1'b1;
        hold_waddr = widx[HAW-1:0];
        hold_wdata = {hi_byte, buf_rdata};
      end
      mrfe_pkg::ST_RD_HDR: begin
        push.valid = 1'b1;
        push.b0    = fc;
        push.b1    = {rn, 1'b0};
        push.two   = 1'b1;
      end
      mrfe_pkg::ST_RD_A: begin
        hold_re = !rd_input;
        in_re   = rd_input;
      end
      mrfe_pkg::ST_RD_D: begin
        push.valid = 1'b1;
        push.b0    = rd_word[15:8];
        push.b1    = rd_word[7:0];
        push.two   = 1'b1;
        push.last  = rd_done;
      end
      mrfe_pkg::ST_ECHO0: begin
        push.valid = 1'b1;
        push.b0    = hdr[0];
        push.b1    = hdr[1];
        push.two   = 1'b1;
      end
      mrfe_pkg::ST_ECHO1: begin
        push.valid = 1'b1;
        push.b0    = hdr[2];
        push.b1    = hdr[3];
        push.two   = 1'b1;
      end
      mrfe_pkg::ST_ECHO2: begin
        push.valid = 1'b1;
        push.b0    = hdr[4];
        push.last  = 1'b1;
      end
      mrfe_pkg::ST_EXC: begin
        push.valid = 1'b1;
        push.b0    = (fc | mrfe_pkg::EXC_FLAG) & mrfe_pkg::BYTE_MASK;
        push.b1    = {6'd0, exc};
        push.two   = 1'b1;
        push.last  = 1'b1;
        push.exc   = exc;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mrfe_pkg::ST_CLEAR;
      clr     <= '0;
      req_len <= '0;
    end else begin
      state <= state_next;
      if (state == mrfe_pkg::ST_CLEAR) begin
        clr <= clr + CLRW'(1);
      end
      if (accept && !req_type) begin
        if (s_tlast) begin
          req_len <= '0;
        end else if (req_len < LW'(PDU_BUFFER)) begin
          req_len <= req_len + LW'(1);
        end else begin
          req_len <= LW'(PDU_BUFFER + 1);
        end
      end
    end
  end

  // payload registers
  logic [LW-1:0] len_cur;
  assign len_cur = (req_len < LW'(PDU_BUFFER)) ? req_len + LW'(1) : LW'(PDU_BUFFER + 1);

  always_ff @(posedge clk) begin
    if (accept && !req_type) begin
      if (req_len < LW'(10)) begin
        hdr[req_len[3:0]] <= pdu_byte;
      end
      len_hold <= len_cur;
    end
    case (state)
      mrfe_pkg::ST_CHECK: begin
        exc      <= chk_code;
        rd_bad   <= chk_rbad;
        rd_input <= (fc == mrfe_pkg::FC_RD_INPUT);
        wi       <= 7'd0;
        ri       <= 7'd0;
        rn       <= cnt_w[6:0];
        ridx     <= IDXW'(addr_w - rd_base);
        case (fc)
          mrfe_pkg::FC_WR_ONE: begin
            src  <= 9'd3;
            wn   <= 7'd1;
            widx <= IDXW'(addr_w - holding_base);
          end
          mrfe_pkg::FC_WR_MULTI: begin
            src  <= 9'd6;
            wn   <= cnt_w[6:0];
            widx <= IDXW'(addr_w - holding_base);
          end
          default: begin
            src  <= 9'd10;
            wn   <= wcnt_w[6:0];
            widx <= IDXW'(waddr_w - holding_base);
          end
        endcase
      end
      mrfe_pkg::ST_WR_B: hi_byte <= buf_rdata;
      mrfe_pkg::ST_WR_C: begin
        wi   <= wi + 7'd1;
        widx <= widx + IDXW'(1);
        src  <= src + 9'd2;
        if (wr_done && rd_bad) begin
          exc <= mrfe_pkg::EX_ADDR;
        end
      end
      mrfe_pkg::ST_RD_D: begin
        if (push_ready) begin
          ri   <= ri + 7'd1;
          ridx <= ridx + IDXW'(1);
        end
      end
      default: ;
    endcase
  end

  mrfe_ram #(.DEPTH(PDU_BUFFER), .WIDTH(8)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(pdu_byte),
    .re(buf_re), .raddr(buf_raddr), .rdata(buf_rdata)
  );

  mrfe_ram #(.DEPTH(HOLD_DEPTH), .WIDTH(16)) u_hold (
    .clk(clk), .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
    .re(hold_re), .raddr(ridx[HAW-1:0]), .rdata(hold_rdata)
  );

  mrfe_ram #(.DEPTH(INPUT_DEPTH), .WIDTH(16)) u_input (
    .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .re(in_re), .raddr(ridx[IAW-1:0]), .rdata(in_rdata)
  );

  mrfe_pack u_pack (
    .clk(clk), .rst(rst), .push(push), .push_ready(push_ready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  `MRFE_AST_IMP(a_no_req_in_clear, state == mrfe_pkg::ST_CLEAR, !s_tready, "request taken during clear")
  `MRFE_AST_IMP(a_exc_single, m_tvalid && m_tuser != mrfe_pkg::EX_NONE, m_tlast && m_tdata[34:32] == 3'd2, "exception item malformed")
  `MRFE_AST_IMP(a_count_range, m_tvalid, m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4, "response byte count out of range")
  `MRFE_AST_IMP(a_store_write_excl, hold_we && state != mrfe_pkg::ST_CLEAR, !hold_re, "holding store read and written together")

endmodule
